// File: rtl/assert_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Clocked implication check, disabled during reset.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Clocked check that also holds during reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

// File: rtl/amb_pkg.sv
// Types, constants and helper functions for the affine matrix builder.
`default_nettype none
package amb_pkg;
  localparam int CORDIC_STEPS = 30;
  localparam int CW = 34;
  localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
    logic [1:0]           quad;
  } cord_t;

  typedef struct packed {
    logic signed [31:0] sx;
    logic signed [31:0] sy;
    logic signed [31:0] sz;
    logic signed [31:0] tx;
    logic signed [31:0] ty;
    logic signed [31:0] tz;
  } carry_t;

  // arctangent of 2^-k in units of 2^-32 turn
  function automatic logic [31:0] atan_turn(input int k);
    logic [31:0] r;
    case (k)
      0: r = 32'h20000000;  1: r = 32'h12E4051D;  2: r = 32'h09FB385B;
      3: r = 32'h051111D4;  4: r = 32'h028B0D43;  5: r = 32'h0145D7E1;
      6: r = 32'h00A2F61E;  7: r = 32'h00517C55;  8: r = 32'h0028BE53;
      9: r = 32'h00145F2E;  10: r = 32'h000A2F98; 11: r = 32'h000517CC;
      12: r = 32'h00028BE6; 13: r = 32'h000145F3; 14: r = 32'h0000A2F9;
      15: r = 32'h0000517C; 16: r = 32'h000028BE; 17: r = 32'h0000145F;
      18: r = 32'h00000A2F; 19: r = 32'h00000517; 20: r = 32'h0000028B;
      21: r = 32'h00000145; 22: r = 32'h000000A2; 23: r = 32'h00000051;
      24: r = 32'h00000028; 25: r = 32'h00000014; 26: r = 32'h0000000A;
      27: r = 32'h00000005; 28: r = 32'h00000002; 29: r = 32'h00000001;
      default: r = 32'h0;
    endcase
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) r = 32'sh7FFFFFFF;
    else if (v < -64'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction
endpackage
`default_nettype wire

// File: rtl/affine_matrix_builder.sv
// Top level: pipelined CORDIC trig and matrix chain emitting four rows per word.
// Row 0 passes through the input register, 30 CORDIC stages, one trig round stage,
// three multiply stages and the row buffer.
// A new input word is taken only when the row buffer is empty or its last row is taken,
// since the single result port drains four rows per matrix from the row buffer.
// Reset (synchronous, rst high) clears all valid bits and the row counter.
`default_nettype none
`include "assert_macros.svh"
module affine_matrix_builder
  import amb_pkg::*;
#(
  parameter int ANGLE_BITS    = 16,
  parameter int FRACTION_BITS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [31:0] scale_x,
  input  wire logic signed [31:0] scale_y,
  input  wire logic signed [31:0] scale_z,
  input  wire logic [15:0]        angle_x,
  input  wire logic [15:0]        angle_y,
  input  wire logic [15:0]        angle_z,
  input  wire logic signed [31:0] offset_x,
  input  wire logic signed [31:0] offset_y,
  input  wire logic signed [31:0] offset_z,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [1:0]              row_index,
  output logic signed [31:0]      elem0,
  output logic signed [31:0]      elem1,
  output logic signed [31:0]      elem2,
  output logic signed [31:0]      elem3,
  output logic                    last_row
);
  localparam int FB = FRACTION_BITS;
  localparam logic signed [31:0] ONE = 32'sd1 <<< FB;
  localparam logic signed [63:0] HALF = 64'sd1 <<< (FB - 1);
  localparam logic signed [CW-1:0] RND = 34'sd1 <<< (29 - FB);
  localparam logic [1:0] LAST = 2'd3;

  // Q4.30 to output format, round half up, clamp to +-1.0
  function automatic logic signed [31:0] to_q(input logic signed [CW-1:0] v);
    logic signed [CW-1:0] r;
    logic signed [31:0] o;
    r = (v + RND) >>> (30 - FB);
    if (r > 34'(ONE)) o = ONE;
    else if (r < -34'(ONE)) o = -ONE;
    else o = r[31:0];
    return o;
  endfunction

  function automatic logic signed [31:0] mulq(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    logic signed [63:0] p;
    p = 64'(a) * 64'(b) + HALF;
    p = p >>> FB;
    return sat32(p);
  endfunction

  // whole pipeline moves together; the row buffer frees on its last row
  logic       adv;
  logic       buf_valid;
  logic [1:0] row;
  assign adv      = !buf_valid || (out_ready && row == LAST);
  assign in_ready = adv;

  // ---------------- CORDIC pipeline, three lanes ----------------
  cord_t  cs [0:CORDIC_STEPS][0:2];
  carry_t cc [0:CORDIC_STEPS];
  logic   cv [0:CORDIC_STEPS];

  logic [15:0] ang_in [0:2];
  assign ang_in[0] = angle_x;
  assign ang_in[1] = angle_y;
  assign ang_in[2] = angle_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      cv[0] <= 1'b0;
    end else if (adv) begin
      cv[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int l = 0; l < 3; l++) begin
        // turn scaled to 32 bits; bits at and above ANGLE_BITS fall off
        logic [31:0] t;
        t = {16'd0, ang_in[l]} << (32 - ANGLE_BITS);
        cs[0][l].x    <= CORDIC_GAIN;
        cs[0][l].y    <= '0;
        cs[0][l].z    <= {4'd0, t[29:0]};
        cs[0][l].quad <= t[31:30];
      end
      cc[0] <= '{sx: scale_x, sy: scale_y, sz: scale_z,
                 tx: offset_x, ty: offset_y, tz: offset_z};
    end
  end

  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_step
    always_ff @(posedge clk) begin
      if (rst) begin
        cv[k+1] <= 1'b0;
      end else if (adv) begin
        cv[k+1] <= cv[k];
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        for (int l = 0; l < 3; l++) begin
          logic signed [CW-1:0] dx, dy, at;
          dx = cs[k][l].y >>> k;
          dy = cs[k][l].x >>> k;
          at = {2'b00, atan_turn(k)};
          if (!cs[k][l].z[CW-1]) begin
            cs[k+1][l].x <= cs[k][l].x - dx;
            cs[k+1][l].y <= cs[k][l].y + dy;
            cs[k+1][l].z <= cs[k][l].z - at;
          end else begin
            cs[k+1][l].x <= cs[k][l].x + dx;
            cs[k+1][l].y <= cs[k][l].y - dy;
            cs[k+1][l].z <= cs[k][l].z + at;
          end
          cs[k+1][l].quad <= cs[k][l].quad;
        end
        cc[k+1] <= cc[k];
      end
    end
  end

  // ---------------- round and place quadrant ----------------
  logic signed [31:0] tcos [0:2];
  logic signed [31:0] tsin [0:2];
  carry_t ct;
  logic   tv;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int l = 0; l < 3; l++) begin
        logic signed [31:0] c, s;
        c = to_q(cs[CORDIC_STEPS][l].x);
        s = to_q(cs[CORDIC_STEPS][l].y);
        case (cs[CORDIC_STEPS][l].quad)
          2'd0: begin tcos[l] <= c;  tsin[l] <= s;  end
          2'd1: begin tcos[l] <= -s; tsin[l] <= c;  end
          2'd2: begin tcos[l] <= -c; tsin[l] <= -s; end
          default: begin tcos[l] <= s; tsin[l] <= -c; end
        endcase
      end
      ct <= cc[CORDIC_STEPS];
    end
  end

  // ---------------- Rx*Ry ----------------
  logic signed [31:0] a [0:2][0:2];
  logic signed [31:0] az_c, az_s;
  carry_t c1;
  logic   v1;

  always_ff @(posedge clk) begin
    if (adv) begin
      a[0][0] <= tcos[1];
      a[0][1] <= '0;
      a[0][2] <= -tsin[1];
      a[1][0] <= mulq(tsin[0], tsin[1]);
      a[1][1] <= tcos[0];
      a[1][2] <= mulq(tsin[0], tcos[1]);
      a[2][0] <= mulq(tcos[0], tsin[1]);
      a[2][1] <= -tsin[0];
      a[2][2] <= mulq(tcos[0], tcos[1]);
      az_c    <= tcos[2];
      az_s    <= tsin[2];
      c1      <= ct;
    end
  end

  // ---------------- (Rx*Ry)*Rz ----------------
  logic signed [31:0] r [0:2][0:2];
  carry_t c2;
  logic   v2;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        r[i][0] <= sat32(64'(mulq(a[i][0], az_c)) - 64'(mulq(a[i][1], az_s)));
        r[i][1] <= sat32(64'(mulq(a[i][0], az_s)) + 64'(mulq(a[i][1], az_c)));
        r[i][2] <= a[i][2];
      end
      c2 <= c1;
    end
  end

  // ---------------- scaling ----------------
  logic signed [31:0] m [0:2][0:2];
  carry_t c3;
  logic   v3;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int j = 0; j < 3; j++) begin
        m[0][j] <= mulq(c2.sx, r[0][j]);
        m[1][j] <= mulq(c2.sy, r[1][j]);
        m[2][j] <= mulq(c2.sz, r[2][j]);
      end
      c3 <= c2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tv <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (adv) begin
      tv <= cv[CORDIC_STEPS];
      v1 <= tv;
      v2 <= v1;
      v3 <= v2;
    end
  end

  // ---------------- row buffer ----------------
  logic signed [31:0] bm [0:2][0:2];
  carry_t bc;

  always_ff @(posedge clk) begin
    if (adv) begin
      bm <= m;
      bc <= c3;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      buf_valid <= 1'b0;
      row       <= '0;
    end else if (adv) begin
      buf_valid <= v3;
      row       <= '0;
    end else if (out_ready) begin
      row <= row + 2'd1;
    end
  end

  assign out_valid = buf_valid;
  assign row_index = row;
  assign last_row  = (row == LAST);

  always_comb begin
    case (row)
      2'd0: begin
        elem0 = bm[0][0]; elem1 = bm[0][1]; elem2 = bm[0][2]; elem3 = '0;
      end
      2'd1: begin
        elem0 = bm[1][0]; elem1 = bm[1][1]; elem2 = bm[1][2]; elem3 = '0;
      end
      2'd2: begin
        elem0 = bm[2][0]; elem1 = bm[2][1]; elem2 = bm[2][2]; elem3 = '0;
      end
      default: begin
        elem0 = bc.tx; elem1 = bc.ty; elem2 = bc.tz; elem3 = ONE;
      end
    endcase
  end

  `ASSERT_CLK(a_row_step, clk, rst,
    out_valid && out_ready && !last_row |=> out_valid && row_index == $past(row_index) + 2'd1,
    "row sequence broken")
  `ASSERT_CLK(a_free_on_last, clk, rst,
    out_valid && out_ready && last_row |-> in_ready,
    "buffer not released on last row")
  `ASSERT_CLK(a_unit_corner, clk, rst,
    out_valid && last_row |-> elem3 == ONE && elem0 == bc.tx,
    "bottom row corrupt")
endmodule
`default_nettype wire
